>>> rtl/core/ace_pkg.sv
`default_nettype none

package ace_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int N_IFACES    = 4;
   localparam int N_CSR       = 4;

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CSR_IDX_W = $clog2(N_CSR);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int IFACE_W = 8;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int OP_W    = 8;
   localparam int STAT_W  = 2;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 56;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BAD_IFC  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_LEARN  = 1'b1;

   localparam logic [OP_W-1:0] ARP_OP_REQUEST = 8'h01;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan;
      logic finish;
   } ace_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic match;
      logic scan_last;
      logic out_free;
   } ace_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/ace_ctrl.sv
`default_nettype none

module ace_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire ace_pkg::ace_stat_type stat,
   output ace_pkg::ace_cmd_type       cmd
);
   import ace_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // The walk ends on the first matching entry or at the last slot.
            if (stat.match || stat.scan_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready  = ready_ff;
   assign cmd.capture = req_tvalid && ready_ff;
   assign cmd.scan    = (state_ff == ST_SCAN);
   assign cmd.finish  = (state_ff == ST_DONE) && stat.out_free;

endmodule

`default_nettype wire

>>> rtl/core/ace_dp.sv
`default_nettype none

module ace_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_cmd,
   input  wire logic [ace_pkg::REQ_DATA_W-1:0]    req_data,
   input  wire logic                              csr_we,
   input  wire logic [ace_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ace_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire ace_pkg::ace_cmd_type              cmd,
   output ace_pkg::ace_stat_type                  stat,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ace_pkg::RSP_DATA_W-1:0]         rsp_data
);
   import ace_pkg::*;

   logic [IP_W-1:0]    iface_addr_ff [N_CSR];

   logic [IFACE_W-1:0] entry_iface_ff [TABLE_DEPTH];
   logic [MAC_W-1:0]   entry_mac_ff   [TABLE_DEPTH];
   logic [IP_W-1:0]    entry_ip_ff    [TABLE_DEPTH];

   logic               item_cmd_ff;
   logic [IFACE_W-1:0] item_ifc_ff;
   logic [IP_W-1:0]    item_ip_ff;
   logic [MAC_W-1:0]   item_mac_ff;
   logic [IP_W-1:0]    item_tip_ff;
   logic [OP_W-1:0]    item_op_ff;

   logic [IDX_W-1:0]   idx_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [MAC_W-1:0]   hit_mac_ff;

   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic                  match_now;
   logic                  ifc_ok;
   logic                  mcast;
   logic [MAC_W-1:0]      mcast_mac;
   logic                  reply;
   logic [STAT_W-1:0]     res_status;
   logic [MAC_W-1:0]      res_mac;
   logic                  res_inserted;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_CSR; i++) iface_addr_ff[i] <= '0;
      end else if (csr_we && (csr_addr < CSR_ADDR_W'(N_CSR))) begin
         iface_addr_ff[csr_addr[CSR_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff <= req_cmd;
         item_ifc_ff <= req_data[7:0];
         item_ip_ff  <= req_data[39:8];
         item_mac_ff <= req_data[87:40];
         item_tip_ff <= req_data[119:88];
         item_op_ff  <= req_data[127:120];
      end
   end

   // One entry is compared per cycle of the walk.
   always_comb begin
      match_now = cmd.scan && (entry_iface_ff[idx_ff] == item_ifc_ff) &&
                  ((item_cmd_ff == CMD_LEARN) ? (entry_mac_ff[idx_ff] == item_mac_ff)
                                              : (entry_ip_ff[idx_ff] == item_ip_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.capture) begin
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (match_now) hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (match_now) begin
         hit_idx_ff <= idx_ff;
         hit_mac_ff <= entry_mac_ff[idx_ff];
      end
   end

   assign stat.match     = match_now;
   assign stat.scan_last = (idx_ff == LAST_IDX);
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   // Result of the item.
   always_comb begin
      ifc_ok    = (item_ifc_ff < IFACE_W'(N_IFACES));
      mcast     = (item_ip_ff[7:5] == 3'b111);
      mcast_mac = {8'h01, 8'h00, 8'h5e, 1'b0, item_ip_ff[14:8],
                   item_ip_ff[23:16], item_ip_ff[31:24]};
      reply     = ifc_ok && (item_tip_ff == iface_addr_ff[item_ifc_ff[CSR_IDX_W-1:0]]) &&
                  (item_op_ff == ARP_OP_REQUEST);
      res_status   = STATUS_OK;
      res_mac      = '0;
      res_inserted = 1'b0;
      if (item_cmd_ff == CMD_LEARN) begin
         res_inserted = !hit_ff;
      end else if (!ifc_ok) begin
         res_status = STATUS_BAD_IFC;
      end else if (mcast) begin
         res_mac = mcast_mac;
      end else if (hit_ff) begin
         res_mac = hit_mac_ff;
      end else begin
         res_status = STATUS_NOT_FOUND;
      end
   end

   // Table write-back: update in place, or shift down and insert at slot zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_iface_ff[i] <= '0;
            entry_mac_ff[i]   <= '0;
            entry_ip_ff[i]    <= '0;
         end
      end else if (cmd.finish && (item_cmd_ff == CMD_LEARN)) begin
         if (hit_ff) begin
            entry_ip_ff[hit_idx_ff] <= item_ip_ff;
         end else begin
            for (int i = 1; i < TABLE_DEPTH; i++) begin
               entry_iface_ff[i] <= entry_iface_ff[i-1];
               entry_mac_ff[i]   <= entry_mac_ff[i-1];
               entry_ip_ff[i]    <= entry_ip_ff[i-1];
            end
            entry_iface_ff[0] <= item_ifc_ff;
            entry_mac_ff[0]   <= item_mac_ff;
            entry_ip_ff[0]    <= item_ip_ff;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_data_ff <= {4'b0000,
                         (item_cmd_ff == CMD_LEARN) && reply,
                         res_inserted, res_mac, res_status};
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/arp_cache_engine.sv
// The table walk compares one entry per cycle and stops at the first match or at the last
// slot; the result is then written to the output register with the table write-back.
// A new beat is taken only after the walk, the write-back and req_tready raised again;
// a result held by rsp_tready stalls the following item in its write-back until the
// output register frees.
// Reset is synchronous: it clears the table and interface addresses; req_tready is low.
`default_nettype none

module arp_cache_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: iface[7:0], ip_addr[39:8], sender_mac[87:40], target_ip[119:88],
   //        arp_op_low[127:120]
   input  wire logic [ace_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: command
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: status[1:0], mac_out[49:2], inserted[50], reply_needed[51], zero pad
   output logic [ace_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [ace_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ace_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ace_pkg::*;

   ace_cmd_type  cmd;
   ace_stat_type stat;

   ace_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ace_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_cmd   (req_tuser),
      .req_data  (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STATUS_OK || rsp_tdata[1:0] == STATUS_BAD_IFC ||
                      rsp_tdata[1:0] == STATUS_NOT_FOUND))
      else $error("undefined status code on result");

   a_fail_no_mac: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != STATUS_OK) |-> (rsp_tdata[49:2] == '0))
      else $error("failed lookup carries a MAC");

   a_learn_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[50] || rsp_tdata[51])) |->
         (rsp_tdata[1:0] == STATUS_OK && rsp_tdata[49:2] == '0))
      else $error("learn result carries lookup fields");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new beat accepted while an item is in the walk");

endmodule

`default_nettype wire

>>> verif/tb_arp_cache_engine.sv
`default_nettype none

module tb_arp_cache_engine;
   import ace_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_IFACE0_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IFACE3_ADDR = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_FIRST = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

   localparam logic [7:0]  MCAST_MASK   = 8'he0;
   localparam logic [23:0] MCAST_PREFIX = 24'h01005e;
   localparam logic [7:0]  ARP_OP_REPLY = 8'h02;

   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 230;
   localparam int POOL_SIZE   = 20;
   localparam int SETTLE      = 24;

   typedef struct packed {
      logic               cmd;
      logic [IFACE_W-1:0] iface;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [IP_W-1:0]    tip;
      logic [OP_W-1:0]    op;
   } arp_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [MAC_W-1:0]  mac;
      logic              inserted;
      logic              reply;
   } arp_rsp_type;

   class arp_cache_scoreboard;
      logic [IP_W-1:0]    iface_addr[N_IFACES];
      logic [IFACE_W-1:0] slot_iface[TABLE_DEPTH];
      logic [MAC_W-1:0]   slot_mac[TABLE_DEPTH];
      logic [IP_W-1:0]    slot_ip[TABLE_DEPTH];
      arp_rsp_type        expected_rsp[$];
      int unsigned        errors;

      function new();
         foreach (iface_addr[i]) iface_addr[i] = '0;
         foreach (slot_iface[i]) begin
            slot_iface[i] = '0;
            slot_mac[i]   = '0;
            slot_ip[i]    = '0;
         end
         errors = 0;
      endfunction

      function void write_addr(int unsigned idx, logic [IP_W-1:0] value);
         if (idx < N_IFACES) iface_addr[idx] = value;
      endfunction

      // Applies one lookup or learn to the cache copy and returns its outcome.
      function arp_rsp_type cache_outcome(arp_req_type r);
         arp_rsp_type o;
         bit          found;
         o = '0;
         found = 0;
         if (r.cmd == CMD_LOOKUP) begin
            if (r.iface >= N_IFACES) begin
               o.status = STATUS_BAD_IFC;
            end else if ((r.ip[7:0] & MCAST_MASK) == MCAST_MASK) begin
               o.mac = {MCAST_PREFIX, 1'b0, r.ip[14:8], r.ip[23:16], r.ip[31:24]};
            end else begin
               o.status = STATUS_NOT_FOUND;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (slot_iface[i] == r.iface && slot_ip[i] == r.ip) begin
                     o.status = STATUS_OK;
                     o.mac    = slot_mac[i];
                     break;
                  end
               end
            end
         end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_iface[i] == r.iface && slot_mac[i] == r.mac) begin
                  slot_ip[i] = r.ip;
                  found = 1;
                  break;
               end
            end
            if (!found) begin
               for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
                  slot_iface[i] = slot_iface[i-1];
                  slot_mac[i]   = slot_mac[i-1];
                  slot_ip[i]    = slot_ip[i-1];
               end
               slot_iface[0] = r.iface;
               slot_mac[0]   = r.mac;
               slot_ip[0]    = r.ip;
               o.inserted = 1'b1;
            end
            if (r.iface < N_IFACES && r.tip == iface_addr[r.iface[1:0]] &&
                r.op == ARP_OP_REQUEST)
               o.reply = 1'b1;
         end
         return o;
      endfunction

      function void note_request(arp_req_type r);
         expected_rsp.push_back(cache_outcome(r));
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] %s", $time, msg);
      endtask

      task check_response(arp_rsp_type got);
         arp_rsp_type want;
         if (expected_rsp.size() == 0) begin
            report("result beat arrived with no request outstanding");
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status)
            report($sformatf("status: got %0d, expected %0d", got.status, want.status));
         if (got.mac !== want.mac)
            report($sformatf("mac_out: got %h, expected %h", got.mac, want.mac));
         if (got.inserted !== want.inserted)
            report($sformatf("inserted: got %b, expected %b", got.inserted, want.inserted));
         if (got.reply !== want.reply)
            report($sformatf("reply_needed: got %b, expected %b", got.reply, want.reply));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   arp_cache_scoreboard sb;
   logic [IP_W-1:0]     ip_pool[POOL_SIZE];
   logic [MAC_W-1:0]    mac_pool[POOL_SIZE];
   int unsigned         rx_hold = 0;

   arp_cache_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_idle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic arp_req_type mk_req(logic cmd, logic [IFACE_W-1:0] iface,
                                          logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                          logic [IP_W-1:0] tip, logic [OP_W-1:0] op);
      arp_req_type r;
      r.cmd = cmd;
      r.iface = iface;
      r.ip = ip;
      r.mac = mac;
      r.tip = tip;
      r.op = op;
      return r;
   endfunction

   // Learns and lookups mostly draw from small pools so that entries get
   // updated, hit and pushed out; the rest is noise over the full field range.
   function automatic arp_req_type random_req();
      arp_req_type r;
      int unsigned roll;
      r.cmd = ($urandom_range(0, 1) == 1) ? CMD_LEARN : CMD_LOOKUP;
      r.iface = ($urandom_range(0, 99) < 85) ? IFACE_W'($urandom_range(0, N_IFACES - 1))
                                              : IFACE_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 75)      r.ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 85) r.ip = $urandom | {24'h0, MCAST_MASK};
      else                r.ip = $urandom;
      r.mac = ($urandom_range(0, 99) < 80) ? mac_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : MAC_W'({$urandom, $urandom});
      roll = $urandom_range(0, 99);
      if (roll < 60)      r.tip = sb.iface_addr[$urandom_range(0, N_IFACES - 1)];
      else if (roll < 80) r.tip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      else                r.tip = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 70)      r.op = ARP_OP_REQUEST;
      else if (roll < 85) r.op = ARP_OP_REPLY;
      else                r.op = OP_W'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic send_req(input arp_req_type r, input int unsigned idle);
      repeat (idle) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = r.cmd;
      req_tdata  = {r.op, r.tip, r.mac, r.ip, r.iface};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_addr(idx, v);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   always @(posedge clock) begin
      arp_req_type seen;
      arp_rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.cmd   = req_tuser;
            seen.iface = req_tdata[7:0];
            seen.ip    = req_tdata[39:8];
            seen.mac   = req_tdata[87:40];
            seen.tip   = req_tdata[119:88];
            seen.op    = req_tdata[127:120];
            sb.note_request(seen);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tdata[1:0];
            got.mac      = rsp_tdata[49:2];
            got.inserted = rsp_tdata[50];
            got.reply    = rsp_tdata[51];
            sb.check_response(got);
         end
      end
   end

   // Result side back-pressure: alternating ready runs and stalls, with
   // occasional long runs where ready stays high.
   always @(negedge clock) begin
      if (rx_hold != 0) begin
         rx_hold = rx_hold - 1;
      end else if (rsp_tready) begin
         rsp_tready = 1'b0;
         rx_hold = pick_idle();
      end else begin
         rsp_tready = 1'b1;
         rx_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 6);
      end
   end

   initial begin
      int unsigned      idle;
      int unsigned      burst_left;
      logic [IP_W-1:0]  v;
      logic [IP_W-1:0]  addr_val;
      sb = new();
      burst_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(REG_IFACE0_ADDR, 32'h0100a8c0);
      write_reg(REG_IFACE0_ADDR + 3'd1, 32'hffffffff);
      write_reg(REG_IFACE0_ADDR + 3'd2, 32'h00000000);
      write_reg(REG_IFACE3_ADDR, 32'h0a00000a);
      // Indexes past the last register must be ignored.
      write_reg(REG_SPARE_FIRST, 32'h0a00000a);
      write_reg(REG_SPARE_LAST, 32'h12345678);

      // Cleared slots match interface 0, address 0.
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'h0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd255, 32'h0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd4, 32'h0101a8c0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd3, 32'h0101a8c0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd1, 32'hffffffff, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd2, 32'h000000e0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'h000000df, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LEARN, 8'd0, 32'hffffff7f, 48'hffffffffffff, 32'h0100a8c0,
                      ARP_OP_REQUEST), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'hffffff7f, 48'h0, 32'h0, 8'h0), pick_idle());
      // Same interface and MAC only rewrites the address.
      send_req(mk_req(CMD_LEARN, 8'd0, 32'h0202a8c0, 48'hffffffffffff, 32'h0100a8c0,
                      ARP_OP_REPLY), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'h0202a8c0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'hffffff7f, 48'h0, 32'h0, 8'h0), pick_idle());
      // MAC zero on interface 0 updates the first cleared slot.
      send_req(mk_req(CMD_LEARN, 8'd0, 32'h0505a8c0, 48'h0, 32'h0, ARP_OP_REQUEST),
               pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'h0, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd0, 32'h0505a8c0, 48'h0, 32'h0, 8'h0), pick_idle());
      // An out-of-range interface is learned but never answered.
      send_req(mk_req(CMD_LEARN, 8'd200, 32'h0d0c0b0a, 48'h0123456789ab, 32'h0,
                      ARP_OP_REQUEST), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd200, 32'h0d0c0b0a, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LEARN, 8'd1, 32'h00000001, 48'h800000000001, 32'hffffffff,
                      ARP_OP_REQUEST), pick_idle());
      send_req(mk_req(CMD_LEARN, 8'd3, 32'h0300000a, 48'h000000000001, 32'h0a00000a,
                      8'h81), pick_idle());
      send_req(mk_req(CMD_LEARN, 8'd2, 32'h0400000a, 48'h7fffffffffff, 32'h0,
                      ARP_OP_REQUEST), pick_idle());
      send_req(mk_req(CMD_LEARN, 8'd4, 32'h0500000a, 48'h7fffffffffff, 32'h0,
                      ARP_OP_REQUEST), pick_idle());
      send_req(mk_req(CMD_LOOKUP, 8'd1, 32'h00000001, 48'h0, 32'h0, 8'h0), pick_idle());
      send_req(mk_req(CMD_LEARN, 8'd255, 32'h0, 48'h0, 32'hffffffff, 8'hff), pick_idle());
      // Lookup ignores the learn-only fields.
      send_req(mk_req(CMD_LOOKUP, 8'd3, 32'h0300000a, 48'hffffffffffff, 32'hffffffff,
                      8'hff), pick_idle());
      wait_for_results();

      for (int p = 0; p < PHASES; p++) begin
         for (int i = 0; i < POOL_SIZE; i++) begin
            v = $urandom;
            if ((v[7:0] & MCAST_MASK) == MCAST_MASK) v[5] = 1'b0;
            ip_pool[i]  = v;
            mac_pool[i] = MAC_W'({$urandom, $urandom});
         end
         for (int k = 0; k < N_IFACES; k++) begin
            if (p == 0)      addr_val = '1;
            else if (p == 1) addr_val = '0;
            else             addr_val = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
            write_reg(REG_IFACE0_ADDR + CSR_ADDR_W'(k), addr_val);
         end
         write_reg(CSR_ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left != 0) begin
               idle = 0;
               burst_left--;
            end else if ($urandom_range(0, 29) == 0) begin
               idle = 0;
               burst_left = $urandom_range(20, 60);
            end else begin
               idle = pick_idle();
            end
            // Once, in the middle of the third phase, let the cache drain completely.
            if (p == 2 && n == PHASE_ITEMS / 2) wait_for_results();
            send_req(random_req(), idle);
         end
         wait_for_results();
      end

      if (sb.errors == 0)
         $display("tb_arp_cache_engine passed");
      else
         $display("tb_arp_cache_engine failed");
      $finish;
   end

   initial begin
      #8000000;
      $display("tb_arp_cache_engine failed");
      $finish;
   end

endmodule

`default_nettype wire
